>>> src/sfc_pkg.sv
package sfc_pkg;

	localparam logic [7:0] FrameEnd = 8'd192;
	localparam logic [7:0] EscLead  = 8'd219;
	localparam logic [7:0] EscEnd   = 8'd220;
	localparam logic [7:0] EscEsc   = 8'd221;
	localparam logic [2:0] MinFrame = 3'd5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_BAD_SUM   = 2'd2,
		ST_BAD_ESC   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_REPORT  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  channel_id;
		logic [15:0] frame_length;
		status_t     status;
	} result_t;

endpackage

>>> src/sfc_core.sv
module sfc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        line_byte,
	output logic              res_valid,
	output sfc_pkg::result_t  res
);

	logic        esc_q;
	logic        hunting_q;
	logic [2:0]  count_q;
	logic [15:0] sum_q;
	logic [7:0]  channel_q;
	logic [15:0] length_q;
	logic [7:0]  older_q;
	logic [7:0]  newer_q;

	logic        esc_d;
	logic        hunting_d;
	logic [2:0]  count_d;
	logic [15:0] sum_d;
	logic [7:0]  channel_d;
	logic [15:0] length_d;
	logic [7:0]  older_d;
	logic [7:0]  newer_d;

	logic        do_take;
	logic        do_close;
	logic        do_bad_esc;
	logic        do_clear;
	logic [7:0]  dec;
	logic [15:0] calc_sum;
	logic [15:0] got_sum;

	// Classify the incoming byte against the current framing state.
	always_comb begin
		do_take    = 1'b0;
		do_close   = 1'b0;
		do_bad_esc = 1'b0;
		do_clear   = 1'b0;
		dec        = line_byte;
		esc_d      = esc_q;
		hunting_d  = hunting_q;
		if (hunting_q) begin
			if (line_byte == sfc_pkg::FrameEnd) begin
				hunting_d = 1'b0;
				do_clear  = 1'b1;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (line_byte == sfc_pkg::EscEnd) begin
				do_take = 1'b1;
				dec     = sfc_pkg::FrameEnd;
			end else if (line_byte == sfc_pkg::EscEsc) begin
				do_take = 1'b1;
				dec     = sfc_pkg::EscLead;
			end else begin
				do_bad_esc = 1'b1;
				do_clear   = 1'b1;
				hunting_d  = (line_byte != sfc_pkg::FrameEnd);
			end
		end else if (line_byte == sfc_pkg::EscLead) begin
			esc_d = 1'b1;
		end else if (line_byte == sfc_pkg::FrameEnd) begin
			do_close = 1'b1;
			do_clear = 1'b1;
		end else begin
			do_take = 1'b1;
		end
	end

	assign calc_sum = sum_q - {8'd0, older_q} - {8'd0, newer_q};
	assign got_sum  = {older_q, newer_q};

	always_comb begin
		res_valid        = 1'b0;
		res.kind         = sfc_pkg::KIND_REPORT;
		res.payload_byte = 8'd0;
		res.channel_id   = channel_q;
		res.frame_length = length_q;
		res.status       = sfc_pkg::ST_OK;
		count_d          = count_q;
		sum_d            = sum_q;
		channel_d        = channel_q;
		length_d         = length_q;
		older_d          = older_q;
		newer_d          = newer_q;
		if (do_take) begin
			unique case (count_q)
				3'd0: channel_d = dec;
				3'd1: length_d  = {dec, 8'd0};
				3'd2: length_d  = {length_q[15:8], dec};
				default: ;
			endcase
			if (count_q >= sfc_pkg::MinFrame) begin
				res_valid        = 1'b1;
				res.kind         = sfc_pkg::KIND_PAYLOAD;
				res.payload_byte = older_q;
				res.channel_id   = 8'd0;
				res.frame_length = 16'd0;
			end else begin
				count_d = count_q + 3'd1;
			end
			older_d = newer_q;
			newer_d = dec;
			sum_d   = sum_q + {8'd0, dec};
		end
		if (do_bad_esc) begin
			res_valid  = 1'b1;
			res.status = sfc_pkg::ST_BAD_ESC;
		end
		if (do_close && count_q != 3'd0) begin
			res_valid = 1'b1;
			if (count_q < sfc_pkg::MinFrame) begin
				res.status = sfc_pkg::ST_SHORT;
			end else if (calc_sum == got_sum) begin
				res.status = sfc_pkg::ST_OK;
			end else begin
				res.status = sfc_pkg::ST_BAD_SUM;
			end
		end
		if (do_clear) begin
			count_d   = 3'd0;
			sum_d     = 16'd0;
			channel_d = 8'd0;
			length_d  = 16'd0;
			older_d   = 8'd0;
			newer_d   = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= 1'b0;
			hunting_q <= 1'b0;
			count_q   <= 3'd0;
			sum_q     <= 16'd0;
			channel_q <= 8'd0;
			length_q  <= 16'd0;
			older_q   <= 8'd0;
			newer_q   <= 8'd0;
		end else if (step) begin
			esc_q     <= esc_d;
			hunting_q <= hunting_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			channel_q <= channel_d;
			length_q  <= length_d;
			older_q   <= older_d;
			newer_q   <= newer_d;
		end
	end

`ifndef SYNTH
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sfc_pkg::MinFrame)
		else $error("byte count ran past saturation");

	a_hunt_no_esc: assert property (@(posedge clk) disable iff (!arst_n)
		hunting_q |-> !esc_q)
		else $error("escape pending while hunting for a frame end");

	a_payload_full: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.kind == sfc_pkg::KIND_PAYLOAD)
		|-> (count_q == sfc_pkg::MinFrame && do_take))
		else $error("payload word emitted before the header was complete");

	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		hunting_q |-> !res_valid)
		else $error("result produced while discarding bytes");
`endif

endmodule

>>> src/slip_frame_checker_unit.sv
// SLIP receive deframer with a 16-bit additive checksum. Each raw line byte
// enters on the slave stream; escapes are undone and a 192 byte closes a frame.
// Decoded bytes from the fourth onward leave as payload words two bytes late,
// so the two trailing checksum bytes never appear, and each closed non-empty frame
// yields one report word carrying channel, length and status, as does a bad
// escape sequence. The block takes one byte per cycle while the master side
// accepts: an input register feeds the framing state update and the output
// register, which holds each result word, and a stall on the master side holds the
// input only once both registers are full.
module slip_frame_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // line_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // payload_byte, channel_id, frame_length, status, zeros
	output logic        m_axis_tuser    // kind
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_free;
	logic              step;
	logic              res_valid;
	sfc_pkg::result_t  res;
	sfc_pkg::result_t  res_q;
	logic              out_valid_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	sfc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.line_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {6'd0, res_q.status, res_q.frame_length,
		res_q.channel_id, res_q.payload_byte};

endmodule
